@@ rtl/kpc_pkg.sv @@
package kpc_pkg;

  // Per-key press phase
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DEBOUNCE,
    PH_JUDGE,
    PH_HELD
  } phase_t;

  // Report codes on press_event
  localparam logic [2:0] EV_NONE  = 3'd0;
  localparam logic [2:0] EV_SHORT = 3'd1;
  localparam logic [2:0] EV_LONG  = 3'd2;
  localparam logic [2:0] EV_MULTI = 3'd3;
  localparam logic [2:0] EV_HOLD  = 3'd4;

  // Bit positions in event_enable
  localparam int EN_SHORT   = 0;
  localparam int EN_LONG    = 1;
  localparam int EN_MULTI   = 2;
  localparam int EN_HOLD    = 3;
  localparam int EN_RELEASE = 4;

  // Register indexes (byte address is 4 * index)
  localparam logic [2:0] REG_PRESSED_LEVEL = 3'd0;
  localparam logic [2:0] REG_DEBOUNCE      = 3'd1;
  localparam logic [2:0] REG_LONG_PRESS    = 3'd2;
  localparam logic [2:0] REG_CLICK_GAP     = 3'd3;
  localparam logic [2:0] REG_MULTI_CLICK   = 3'd4;
  localparam logic [2:0] REG_EVENT_ENABLE  = 3'd5;

  localparam int PADDR_W = 5;

  // Configuration as seen by the classifier
  typedef struct packed {
    logic        pressed_level;
    logic [15:0] debounce_ticks;
    logic [15:0] long_press_ticks;
    logic [15:0] click_gap_ticks;
    logic [7:0]  multi_click_count;
    logic [4:0]  event_enable;
  } cfg_t;

endpackage

@@ rtl/kpc_ram.sv @@
module kpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port; read port returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/kpc_step.sv @@
module kpc_step #(
  parameter int COUNT_BITS = 16
) (
  input  kpc_pkg::cfg_t          cfg,
  input  logic                   level,
  input  kpc_pkg::phase_t        phase_in,
  input  logic [COUNT_BITS-1:0]  press_in,
  input  logic [7:0]             tally_in,
  input  logic [COUNT_BITS-1:0]  gap_in,
  input  logic                   held_in,
  output kpc_pkg::phase_t        phase_out,
  output logic [COUNT_BITS-1:0]  press_out,
  output logic [7:0]             tally_out,
  output logic [COUNT_BITS-1:0]  gap_out,
  output logic                   held_out,
  output logic [2:0]             event_code,
  output logic                   rel
);
  import kpc_pkg::*;

  localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  logic                  down;
  logic [COUNT_BITS-1:0] press_inc;
  logic [COUNT_BITS-1:0] gap_inc;
  logic [CW-1:0]         press_w;
  logic [CW-1:0]         gap_w;
  logic [CW-1:0]         deb_w;
  logic [CW-1:0]         long_w;
  logic [CW-1:0]         gapcfg_w;
  logic                  press_ge_deb;
  logic                  press_ge_long;
  logic                  gap_closed;
  logic [2:0]            st;

  assign down      = (level == cfg.pressed_level);
  assign press_inc = (press_in == '1) ? press_in : press_in + 1'b1;
  assign gap_inc   = (gap_in == '1) ? gap_in : gap_in + 1'b1;

  assign press_w  = CW'(press_inc);
  assign gap_w    = CW'(gap_inc);
  assign deb_w    = CW'(cfg.debounce_ticks);
  assign long_w   = CW'(cfg.long_press_ticks);
  assign gapcfg_w = CW'(cfg.click_gap_ticks);

  assign press_ge_deb  = (press_w >= deb_w);
  assign press_ge_long = (press_w >= long_w);
  assign gap_closed    = (gap_w >= gapcfg_w);

  // Advance the press phase and classify the sample
  always_comb begin
    phase_out = phase_in;
    press_out = press_in;
    st        = EV_NONE;
    unique case (phase_in)
      PH_IDLE: begin
        if (down) begin
          phase_out = PH_DEBOUNCE;
        end
      end
      PH_DEBOUNCE: begin
        if (down) begin
          press_out = press_inc;
          if (press_ge_deb) begin
            phase_out = PH_JUDGE;
          end
        end else begin
          press_out = '0;
          phase_out = PH_IDLE;
        end
      end
      PH_JUDGE: begin
        if (down) begin
          press_out = press_inc;
          if (press_ge_long) begin
            st        = EV_LONG;
            phase_out = PH_HELD;
          end
        end else begin
          // compare the unincremented count on release
          st        = (CW'(press_in) >= long_w) ? EV_LONG : EV_SHORT;
          press_out = '0;
          phase_out = PH_IDLE;
        end
      end
      PH_HELD: begin
        if (down) begin
          st = EV_HOLD;
        end else begin
          press_out = '0;
          phase_out = PH_IDLE;
        end
      end
      default: begin
        phase_out = PH_IDLE;
      end
    endcase
  end

  // Turn the classification into a report; track clicks, gap and hold
  always_comb begin
    gap_out    = gap_inc;
    tally_out  = tally_in;
    held_out   = held_in;
    event_code = EV_NONE;
    rel        = 1'b0;
    unique case (st)
      EV_SHORT: begin
        gap_out = '0;
        if (cfg.multi_click_count != 8'd0) begin
          if (tally_in != 8'hFF) begin
            tally_out = tally_in + 8'd1;
          end
        end else if (cfg.event_enable[EN_SHORT]) begin
          event_code = EV_SHORT;
        end
      end
      EV_LONG: begin
        if (cfg.event_enable[EN_LONG]) begin
          event_code = EV_LONG;
        end
      end
      EV_HOLD: begin
        held_out = 1'b1;
        if (cfg.event_enable[EN_HOLD]) begin
          event_code = EV_HOLD;
        end
      end
      default: begin
        if (gap_closed) begin
          if ((cfg.multi_click_count != 8'd0) && (tally_in >= cfg.multi_click_count) &&
              cfg.event_enable[EN_MULTI]) begin
            event_code = EV_MULTI;
          end else if (cfg.event_enable[EN_SHORT] && (tally_in != 8'd0)) begin
            event_code = EV_SHORT;
          end
          tally_out = 8'd0;
        end
        rel      = held_in & cfg.event_enable[EN_RELEASE];
        held_out = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/key_press_classifier_core.sv @@
// Key press classifier for up to NUM_KEYS keys sharing one sample stream.
// Input channel (in_valid / in_stall): one request per tick sample, carrying
// key_index and the sampled level. Output channel (out_valid / out_stall):
// exactly one result per request, in order, with the echoed key index, the
// press_event code and the released_after_hold flag.
// Configuration is written over the APB port at byte address 4 * index; the
// user must write only while no request is in flight; the block won't check.
// A request passes the compute stage, then the output register.
// Throughput: one request per cycle unless out_stall holds the output. Each
// request is a read-modify-write of the key's record in a single RAM with a
// registered read; same-key write-backs on the read edge are forwarded.
// Reset (rst, synchronous) restores the register defaults, empties both
// stages and clears the per-key valid bits, so every key reads as idle with
// zero counters; there is no clearing pass.
// When out_stall is high, the result holds in the output register; one more
// request is taken into the compute stage, then in_stall rises until the
// output register drains.
module key_press_classifier_core #(
  parameter int NUM_KEYS   = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kpc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // sample requests
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [3:0]                  key_index,
  input  logic                        level,
  // results
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [3:0]                  key_out_index,
  output logic [2:0]                  press_event,
  output logic                        released_after_hold
);
  import kpc_pkg::*;

  localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int RW = 2 + COUNT_BITS + 8 + COUNT_BITS + 1;
  localparam logic [8:0] NUM_KEYS_W = 9'(NUM_KEYS);

  // Configuration registers
  cfg_t cfg;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pressed_level     <= 1'b0;
      cfg.debounce_ticks    <= 16'd2;
      cfg.long_press_ticks  <= 16'd100;
      cfg.click_gap_ticks   <= 16'd30;
      cfg.multi_click_count <= 8'd0;
      cfg.event_enable      <= 5'h1F;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_PRESSED_LEVEL: cfg.pressed_level     <= pwdata[0];
        REG_DEBOUNCE:      cfg.debounce_ticks    <= pwdata[15:0];
        REG_LONG_PRESS:    cfg.long_press_ticks  <= pwdata[15:0];
        REG_CLICK_GAP:     cfg.click_gap_ticks   <= pwdata[15:0];
        REG_MULTI_CLICK:   cfg.multi_click_count <= pwdata[7:0];
        REG_EVENT_ENABLE:  cfg.event_enable      <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[4:2])
      REG_PRESSED_LEVEL: prdata = {31'd0, cfg.pressed_level};
      REG_DEBOUNCE:      prdata = {16'd0, cfg.debounce_ticks};
      REG_LONG_PRESS:    prdata = {16'd0, cfg.long_press_ticks};
      REG_CLICK_GAP:     prdata = {16'd0, cfg.click_gap_ticks};
      REG_MULTI_CLICK:   prdata = {24'd0, cfg.multi_click_count};
      REG_EVENT_ENABLE:  prdata = {27'd0, cfg.event_enable};
      default:           prdata = 32'd0;
    endcase
  end

  // Request decode
  logic          in_fire;
  logic [8:0]    key_ext;
  logic [AW-1:0] rd_addr;
  logic          rd_in_range;

  assign in_fire     = in_valid & ~in_stall;
  assign key_ext     = {5'd0, key_index};
  assign rd_addr     = key_ext[AW-1:0];
  assign rd_in_range = (key_ext < NUM_KEYS_W);

  // Compute stage registers
  logic          s1_valid;
  logic [3:0]    s1_key;
  logic [AW-1:0] s1_addr;
  logic          s1_in_range;
  logic          s1_level;
  logic          s1_ent_vld;
  logic          fwd_hit;
  logic [RW-1:0] fwd_rec;
  logic          s1_adv;
  logic          wr_en;

  logic [NUM_KEYS-1:0] ent_vld;
  logic [RW-1:0]       ram_rdata;
  logic [RW-1:0]       cur_rec;
  logic [RW-1:0]       new_rec;

  assign s1_adv   = s1_valid & (~out_valid | ~out_stall);
  assign in_stall = s1_valid & ~s1_adv;
  assign wr_en    = s1_adv & s1_in_range;

  kpc_ram #(
    .WIDTH (RW),
    .DEPTH (NUM_KEYS)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr),
    .wdata (new_rec),
    .re    (in_fire),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Advance the compute stage; capture a same-edge write-back for forwarding
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
      fwd_hit  <= wr_en & (s1_addr == rd_addr);
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_key      <= key_index;
      s1_addr     <= rd_addr;
      s1_in_range <= rd_in_range;
      s1_level    <= level;
      s1_ent_vld  <= rd_in_range & ent_vld[rd_addr];
      fwd_rec     <= new_rec;
    end
  end

  // Mark entries as written; unwritten entries read as the reset record
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_vld <= '0;
    end else if (wr_en) begin
      ent_vld[s1_addr] <= 1'b1;
    end
  end

  assign cur_rec = fwd_hit ? fwd_rec : (s1_ent_vld ? ram_rdata : '0);

  // Unpack, classify, repack
  logic [1:0]            cur_phase;
  logic [COUNT_BITS-1:0] cur_press;
  logic [7:0]            cur_tally;
  logic [COUNT_BITS-1:0] cur_gap;
  logic                  cur_held;
  phase_t                nxt_phase;
  logic [COUNT_BITS-1:0] nxt_press;
  logic [7:0]            nxt_tally;
  logic [COUNT_BITS-1:0] nxt_gap;
  logic                  nxt_held;
  logic [2:0]            step_event;
  logic                  step_rel;

  assign {cur_phase, cur_press, cur_tally, cur_gap, cur_held} = cur_rec;
  assign new_rec = {nxt_phase, nxt_press, nxt_tally, nxt_gap, nxt_held};

  kpc_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .cfg        (cfg),
    .level      (s1_level),
    .phase_in   (phase_t'(cur_phase)),
    .press_in   (cur_press),
    .tally_in   (cur_tally),
    .gap_in     (cur_gap),
    .held_in    (cur_held),
    .phase_out  (nxt_phase),
    .press_out  (nxt_press),
    .tally_out  (nxt_tally),
    .gap_out    (nxt_gap),
    .held_out   (nxt_held),
    .event_code (step_event),
    .rel        (step_rel)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      key_out_index       <= s1_key;
      press_event         <= s1_in_range ? step_event : EV_NONE;
      released_after_hold <= s1_in_range & step_rel;
    end
  end

endmodule

@@ rtl/kpc_checker.sv @@
module kpc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] press_event,
  input logic       released_after_hold
);
  import kpc_pkg::*;

  // Input backs up only behind a stalled, full output register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled result");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // Report codes stay in range
  a_event_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (press_event <= EV_HOLD))
    else $error("press_event out of range");

  // Release after hold never comes with a hold repeat or long report
  a_rel_excl: assert property (@(posedge clk) disable iff (rst)
    (out_valid && released_after_hold) |->
      (press_event != EV_HOLD && press_event != EV_LONG))
    else $error("release flag with hold or long report");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(press_event)))
    else $error("stalled result changed");

endmodule

bind key_press_classifier_core kpc_checker u_kpc_checker (
  .clk                 (clk),
  .rst                 (rst),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .press_event         (press_event),
  .released_after_hold (released_after_hold)
);
